### design/bue_pkg.sv
package bue_pkg;

  localparam int unsigned NumSlots = 3;

  // trailing marker that closes every message
  localparam logic [7:0] EqChar = 8'h3d;

  typedef struct packed {
    logic [NumSlots-1:0][7:0] chr;
    logic [NumSlots-1:0]      last;
    logic [1:0]               cnt;
  } grp_t;

  // 6-bit group to alphabet symbol: A-Z, a-z, 0-9, '-', '~'
  function automatic logic [7:0] sym(input logic [5:0] g);
    logic [7:0] r;
    if (g < 6'd26) begin
      r = 8'h41 + {2'b00, g};
    end else if (g < 6'd52) begin
      r = 8'h61 + ({2'b00, g} - 8'd26);
    end else if (g < 6'd62) begin
      r = 8'h30 + ({2'b00, g} - 8'd52);
    end else if (g == 6'd62) begin
      r = 8'h2d;
    end else begin
      r = 8'h7e;
    end
    return r;
  endfunction

endpackage

### design/bue_enc.sv
module bue_enc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  logic              adv,
  output bue_pkg::grp_t     grp
);

  logic [3:0] lval_r;
  logic [2:0] lcnt_r;

  logic [2:0]  cnt_sat;
  logic [4:0]  lmask;
  logic [11:0] acc;
  logic [3:0]  total;
  logic [3:0]  sh1;
  logic [11:0] shifted;
  logic        two;
  logic [3:0]  rem_w;
  logic [2:0]  rem;
  logic [5:0]  rmask;
  logic [4:0]  remv;
  logic [5:0]  flush;
  logic [1:0]  n;

  always_comb begin
    cnt_sat = (lcnt_r > 3'd4) ? 3'd4 : lcnt_r;
    lmask   = (5'd1 << cnt_sat) - 5'd1;
    acc     = {lval_r & lmask[3:0], data_byte};
    total   = {1'b0, cnt_sat} + 4'd8;
    two     = (total >= 4'd12);
    sh1     = total - 4'd6;
    shifted = acc >> sh1;
    rem_w   = two ? (total - 4'd12) : (total - 4'd6);
    rem     = rem_w[2:0];
    rmask   = (6'd1 << rem) - 6'd1;
    remv    = acc[4:0] & rmask[4:0];
    flush   = {1'b0, remv} << (3'd6 - rem);

    grp      = '0;
    grp.chr[0] = bue_pkg::sym(shifted[5:0]);
    n        = 2'd1;
    if (two) begin
      grp.chr[1] = bue_pkg::sym(acc[5:0]);
      n          = 2'd2;
    end
    if (final_byte) begin
      if (rem != 3'd0) begin
        grp.chr[n] = bue_pkg::sym(flush);
        n          = n + 2'd1;
      end
      grp.chr[n]  = bue_pkg::EqChar;
      grp.last[n] = 1'b1;
      n           = n + 2'd1;
    end
    grp.cnt = n;
  end

  // leftover bits carried to the next byte, cleared at message end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lval_r <= '0;
      lcnt_r <= '0;
    end else if (adv) begin
      if (final_byte) begin
        lval_r <= '0;
        lcnt_r <= '0;
      end else begin
        lval_r <= remv[3:0];
        lcnt_r <= rem;
      end
    end
  end

endmodule

### design/bue_queue.sv
module bue_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  bue_pkg::grp_t grp_in,
  input  logic          grp_valid,
  output logic          grp_take,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_last_char
);

  bue_pkg::grp_t hold_r;
  logic [1:0]    hcnt_r;
  logic [1:0]    hcnt_nxt;
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_last_r;
  logic          pop;

  assign pop      = (hcnt_r != 2'd0) && (!out_valid_r || !out_stall);
  assign grp_take = grp_valid && ((hcnt_r == 2'd0) || ((hcnt_r == 2'd1) && pop));

  always_comb begin
    if (grp_take) begin
      hcnt_nxt = grp_in.cnt;
    end else if (pop) begin
      hcnt_nxt = hcnt_r - 2'd1;
    end else begin
      hcnt_nxt = hcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hcnt_r <= hcnt_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= (hcnt_r != 2'd0);
      end
    end
  end

  // payload: head slot goes to the output, remaining slots shift down
  always_ff @(posedge clk) begin
    if (pop) begin
      out_char_r <= hold_r.chr[0];
      out_last_r <= hold_r.last[0];
    end
    if (grp_take) begin
      hold_r <= grp_in;
    end else if (pop) begin
      hold_r.chr[0]  <= hold_r.chr[1];
      hold_r.chr[1]  <= hold_r.chr[2];
      hold_r.last[0] <= hold_r.last[1];
      hold_r.last[1] <= hold_r.last[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule

### design/base64_url_style_encoder.sv
// byte-stream encoder to 6-bit symbols (A-Z a-z 0-9 - ~), one input byte per
// item, one ascii character per result item. leftover bits (0, 2 or 4) are
// kept between bytes; on the byte flagged final they are flushed zero-padded
// as one more character, followed by a single '=' with out_last_char set,
// and the block is ready for a new message. a byte yields 1 to 3 characters
// and the result channel carries one character per cycle while out_stall is
// low, so in a long stream the rate is set by the single output port draining
// the character queue. a byte's characters pass from the input register
// through the queue's hold register to the output register. a new byte is taken
// while the previous one's characters are still draining.
module base64_url_style_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_char
);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fin_r;

  bue_pkg::grp_t grp;
  logic          take;
  logic          in_load;

  // input register frees when its item moves into the character queue
  assign in_load  = !in_vld_r || take;
  assign in_stall = !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte_r <= in_data_byte;
      in_fin_r  <= in_final_byte;
    end
  end

  // splits the byte into up to three characters and advances leftover state
  bue_enc u_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (in_byte_r),
    .final_byte (in_fin_r),
    .adv        (take),
    .grp        (grp)
  );

  // holds the characters of one byte and hands them out one per cycle unless out_stall holds them
  bue_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .grp_in        (grp),
    .grp_valid     (in_vld_r),
    .grp_take      (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

### test/base64_url_style_encoder_test.sv
`timescale 1ns / 1ps

module base64_url_style_encoder_test;

  // one encoded character as it leaves the block
  typedef struct packed {
    logic [7:0] chr;
    logic       is_last;
  } enc_char_t;

  // one row of the directed table; typed rows carry their three characters
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [23:0] chars;
  } dir_row_t;

  // alphabet, first symbol in the top byte
  localparam logic [8*64-1:0] SymbolSet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-~";

  localparam int RandItems  = 300;
  localparam int PhaseLen   = 60;
  localparam int HoldCycles = 120;
  localparam int DrainWait  = 20;
  localparam int CycleLimit = 200000;

  // directed messages: single bytes at the extremes, the '-' and '~' symbols,
  // and messages that close with 0, 2 and 4 bits still pending
  localparam dir_row_t DirRows [20] = '{
    '{8'h00, 1'b1, 1'b1, "AA="},   // all zeros, two bits flushed
    '{8'hff, 1'b1, 1'b1, "~w="},   // all ones, top symbol then padded 11
    '{8'hfc, 1'b1, 1'b1, "~A="},
    '{8'h03, 1'b1, 1'b1, "Aw="},
    '{8'hf8, 1'b0, 1'b0, 24'd0},   // '-' symbol
    '{8'h00, 1'b0, 1'b0, 24'd0},
    '{8'h00, 1'b1, 1'b0, 24'd0},   // three bytes, nothing left to flush
    '{8'hfb, 1'b0, 1'b0, 24'd0},
    '{8'hef, 1'b0, 1'b0, 24'd0},
    '{8'hbe, 1'b1, 1'b0, 24'd0},
    '{8'h55, 1'b0, 1'b0, 24'd0},
    '{8'haa, 1'b1, 1'b0, 24'd0},   // four bits flushed
    '{8'hff, 1'b0, 1'b0, 24'd0},
    '{8'hff, 1'b0, 1'b0, 24'd0},
    '{8'hff, 1'b0, 1'b0, 24'd0},
    '{8'hff, 1'b1, 1'b0, 24'd0},   // four bytes, two bits flushed
    '{8'h80, 1'b1, 1'b0, 24'd0},
    '{8'h01, 1'b1, 1'b0, 24'd0},
    '{8'h7f, 1'b0, 1'b0, 24'd0},
    '{8'hfe, 1'b1, 1'b0, 24'd0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last_char;

  // predictor state: bits not yet sent, right-aligned, and how many
  logic [3:0] carry_bits = 4'd0;
  logic [2:0] carry_cnt = 3'd0;

  enc_char_t pending_chars [$];
  int        mismatches = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  logic      pressure_go = 1'b0;
  logic      hold_on = 1'b0;

  base64_url_style_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last_char(out_last_char)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] symbol(input logic [5:0] g);
    return SymbolSet[8*(63 - int'(g)) +: 8];
  endfunction

  // encode one byte against the carried bits; returns how many characters
  function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                     output enc_char_t res [3]);
    logic [11:0] acc;
    int          cnt;
    int          n;
    n = 0;
    cnt = int'(carry_cnt);
    if (cnt > 4) cnt = 4;  // only 0, 2 or 4 can occur
    acc = (({8'd0, carry_bits} & ((12'd1 << cnt) - 12'd1)) << 8) | {4'd0, b};
    cnt += 8;
    // every full 6-bit group goes out, oldest bits first
    while (cnt >= 6) begin
      res[n] = '{symbol(6'(acc >> (cnt - 6))), 1'b0};
      n++;
      cnt -= 6;
    end
    acc &= (12'd1 << cnt) - 12'd1;
    if (fin) begin
      // leftover padded with zeros on the right, then the closing '='
      if (cnt > 0) begin
        res[n] = '{symbol(6'(acc << (6 - cnt))), 1'b0};
        n++;
      end
      res[n] = '{bue_pkg::EqChar, 1'b1};
      n++;
      carry_bits = 4'd0;
      carry_cnt = 3'd0;
    end else begin
      carry_bits = acc[3:0];
      carry_cnt = 3'(cnt);
    end
    return n;
  endfunction

  // offer one byte from a falling edge, wait for it to be taken, queue what it
  // should produce; returns at a falling edge with in_valid still high
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [23:0] typed_chars);
    enc_char_t res [3];
    int        n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = encode_byte(b, fin, res);
    if (typed) begin
      for (int k = 0; k < 3; k++)
        pending_chars.push_back('{typed_chars[8*(2-k) +: 8], k == 2});
    end else begin
      for (int k = 0; k < n; k++) pending_chars.push_back(res[k]);
    end
    @(negedge clk);
  endtask

  // receiver: random stall, or a long hold-off during the pressure phase
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  // long hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_on <= 1'b0;
  end

  // compare each accepted character with the oldest expectation
  always @(posedge clk) begin : check_out
    enc_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual %h last %b",
                 $time, out_char, out_last_char);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.chr) begin
          $display("%0t: out_char expected %h actual %h", $time, want.chr, out_char);
          mismatches++;
        end
        if (out_last_char !== want.is_last) begin
          $display("%0t: out_last_char expected %b actual %b",
                   $time, want.is_last, out_last_char);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int         msg_left;
    int         idx;
    logic [7:0] b;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling on either side
    foreach (DirRows[i])
      send_byte(DirRows[i].data, DirRows[i].fin, DirRows[i].typed, DirRows[i].chars);

    // random messages; idling changes by phase, messages may span phases
    msg_left = 0;
    idx = 0;
    while (idx < RandItems || msg_left != 0) begin
      case (idx / PhaseLen)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 81;
        end
        3: begin
          send_idle_pct = 20;
          stall_pct = 20;
        end
        default: begin
          // fill the block: receiver holds off, sender never idles
          send_idle_pct = 0;
          stall_pct = 0;
          pressure_go = 1'b1;
        end
      endcase
      if (msg_left == 0)
        msg_left = ($urandom_range(4) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
      // lean on all-zero and all-one bytes now and then
      if ($urandom_range(7) == 0) b = $urandom_range(1) ? 8'hff : 8'h00;
      else b = 8'($urandom_range(255));
      send_byte(b, msg_left == 1, 1'b0, 24'd0);
      msg_left--;
      idx++;
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
